// ----- hw/rtl/modular_exponentiation_top_macros.svh -----
// Assertion macros for the modular exponentiation block.
// Taken in by the top level; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MX_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("modexp check failed");
`define MX_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("modexp check failed");
`else
`define MX_ASSERT_IMPL(label, clk, rst, prop)
`define MX_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

// ----- hw/rtl/modexp_pkg.sv -----
// Shared types and constants of the modular exponentiation block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  localparam int FIELD_W       = 32;  // width of every operand and result port field
  localparam int DATA_WIDTH_DEF = 32; // default operand width

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_SQUARE,
    ST_SQ_END,
    ST_MULT,
    ST_MUL_END,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // latch operands, start base reduction
    logic step;         // one shift-add-reduce step
    logic commit_base;  // reduced base <= step result
    logic commit_res;   // running residue <= step result
    logic init_sq;      // start res * res
    logic init_mul;     // start res * base
    logic e_adv;        // move to next exponent bit
    logic out_load;     // fill output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;      // exponent or modulus zero: result known at load
    logic cnt_last;  // last step of current reduction/product
    logic e_bit;     // current exponent bit
    logic e_last;    // current exponent bit is the last one
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/modexp_ifs.sv -----
// Valid/ready channel interfaces for input and result items.
// Depends on modexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface modexp_in_if
  import modexp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base_value;
  logic [FIELD_W-1:0] exponent;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, output base_value, output exponent, output modulus,
                  input ready);
  modport sink   (input valid, input base_value, input exponent, input modulus,
                  output ready);
endinterface

interface modexp_out_if
  import modexp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_residue;
  logic               zero_modulus;

  modport source (output valid, output power_residue, output zero_modulus,
                  input ready);
  modport sink   (input valid, input power_residue, input zero_modulus,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/modexp_ctrl.sv -----
// Sequencer of the modular exponentiation block: state machine and
// output-valid flag. Depends on modexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module modexp_ctrl
  import modexp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_CHECK;
      ST_CHECK:   state_next = status.skip ? ST_DONE : ST_REDUCE;
      ST_REDUCE:  if (status.cnt_last) state_next = ST_SQUARE;
      ST_SQUARE:  if (status.cnt_last) state_next = ST_SQ_END;
      ST_SQ_END: begin
        if (status.e_bit)       state_next = ST_MULT;
        else if (status.e_last) state_next = ST_DONE;
        else                    state_next = ST_SQUARE;
      end
      ST_MULT:    if (status.cnt_last) state_next = ST_MUL_END;
      ST_MUL_END: state_next = status.e_last ? ST_DONE : ST_SQUARE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.load = in_valid;
      ST_CHECK:  ;
      ST_REDUCE: begin
        cmd.step        = 1'b1;
        cmd.commit_base = status.cnt_last;
        cmd.init_sq     = status.cnt_last;
      end
      ST_SQUARE: begin
        cmd.step       = 1'b1;
        cmd.commit_res = status.cnt_last;
      end
      ST_SQ_END: begin
        if (status.e_bit) begin
          cmd.init_mul = 1'b1;
        end else if (!status.e_last) begin
          cmd.e_adv   = 1'b1;
          cmd.init_sq = 1'b1;
        end
      end
      ST_MULT: begin
        cmd.step       = 1'b1;
        cmd.commit_res = status.cnt_last;
      end
      ST_MUL_END: begin
        if (!status.e_last) begin
          cmd.e_adv   = 1'b1;
          cmd.init_sq = 1'b1;
        end
      end
      ST_DONE:   cmd.out_load = out_free;
      default:   ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/modexp_dp.sv -----
// Datapath: operand registers, shared shift-add-reduce unit, residue and
// output registers. Depends on modexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module modexp_dp
  import modexp_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [FIELD_W-1:0] base_value,
  input  logic [FIELD_W-1:0] exponent,
  input  logic [FIELD_W-1:0] modulus,
  output logic [FIELD_W-1:0] power_residue,
  output logic               zero_modulus
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]  b_w, e_w, m_w;
  logic [W-1:0]  acc, a_reg, mb, m_reg, base_r, res, e_sh;
  logic [W:0]    m2;
  logic [CW-1:0] cnt, eidx;
  logic          mul_mode, skip, flag;

  logic [W-1:0]  addend;
  logic [W+1:0]  t, d1, d2;
  logic [W-1:0]  acc_next;

  assign b_w = W'(base_value);
  assign e_w = W'(exponent);
  assign m_w = W'(modulus);

  // 2*acc + addend < 3m; take off 2m or m, whichever leaves it in range
  assign addend   = mul_mode ? (mb[W-1] ? a_reg : '0) : W'(mb[W-1]);
  assign t        = {1'b0, acc, 1'b0} + {2'b00, addend};
  assign d1       = t - {2'b00, m_reg};
  assign d2       = t - {1'b0, m2};
  assign acc_next = !d2[W+1] ? d2[W-1:0] : (!d1[W+1] ? d1[W-1:0] : t[W-1:0]);

  assign status.skip     = skip;
  assign status.cnt_last = (cnt == CW'(W - 1));
  assign status.e_bit    = e_sh[W-1];
  assign status.e_last   = (eidx == CW'(W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mb       <= b_w;
      acc      <= '0;
      cnt      <= '0;
      mul_mode <= 1'b0;
      m_reg    <= m_w;
      m2       <= {m_w, 1'b0};
      e_sh     <= e_w;
      eidx     <= '0;
      skip     <= (e_w == '0) || (m_w == '0);
      flag     <= (e_w != '0) && (m_w == '0);
      // exponent zero gives one; modulus zero or one gives zero
      if (e_w == '0)               res <= W'(1);
      else if (m_w <= W'(1))       res <= '0;
      else                         res <= W'(1);
    end
    // a new product start takes priority over the last step of the old one
    if (cmd.init_sq || cmd.init_mul) begin
      a_reg    <= res;
      mb       <= cmd.init_mul ? base_r : res;
      acc      <= '0;
      cnt      <= '0;
      mul_mode <= 1'b1;
    end else if (cmd.step) begin
      acc <= acc_next;
      mb  <= {mb[W-2:0], 1'b0};
      cnt <= cnt + CW'(1);
    end
    if (cmd.commit_base) base_r <= acc_next;
    if (cmd.commit_res)  res    <= acc_next;
    if (cmd.e_adv) begin
      e_sh <= {e_sh[W-2:0], 1'b0};
      eidx <= eidx + CW'(1);
    end
    if (cmd.out_load) begin
      power_residue <= FIELD_W'(res);
      zero_modulus  <= flag;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/modular_exponentiation_top.sv -----
// Top level of the modular exponentiation block: controller, datapath,
// channel wiring and checks. Depends on modexp_pkg, modexp_ifs, modexp_ctrl,
// modexp_dp and modular_exponentiation_top_macros.svh.
//
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   base_value[31:0], exponent[31:0], modulus[31:0]
//  out_chan  out  valid/ready   power_residue[31:0], zero_modulus
//
// Work per item (W = DATA_WIDTH): base reduction, then per exponent bit,
//   MSB first, a square and, if the bit is set, a multiply by the base;
//   none when the exponent or the modulus is zero. All on the one shared
//   shift-add-reduce unit, which consumes one multiplier bit per cycle.
// Reset (rst, synchronous) returns the controller to idle and empties the
//   output register. A stalled result waits in the output register while
//   the next item is taken and worked on; it finishes only when it drains.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top
  import modexp_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  modexp_in_if.sink   in_chan,
  modexp_out_if.source out_chan
);

  cmd_t    cmd;
  status_t status;

  // sequencing only; every operand stays in the datapath
  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // operands are taken in at the accept edge through cmd.load
  modexp_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .base_value    (in_chan.base_value),
    .exponent      (in_chan.exponent),
    .modulus       (in_chan.modulus),
    .power_residue (out_chan.power_residue),
    .zero_modulus  (out_chan.zero_modulus)
  );

  // one item in flight: no second accept right behind the first
  `MX_ASSERT_NEXT(a_one_in_flight, clk, rst, in_chan.valid && in_chan.ready, !in_chan.ready)
  // a zero modulus always comes with a zero residue
  `MX_ASSERT_IMPL(a_zero_mod_res, clk, rst, out_chan.valid && out_chan.zero_modulus |-> out_chan.power_residue == '0)
  // output register is only refilled once the previous item is gone
  `MX_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.out_load |-> (!out_chan.valid || out_chan.ready))

endmodule

`default_nettype wire
